@@ hw/rtl/s2d_pkg.sv @@
// Shared types and constants for the signed integer to decimal ASCII converter.
// Used by s2d_dabble and signed_int_to_decimal_ascii; no dependencies.
`default_nettype none

package s2d_pkg;

  localparam int NUM_W = 32;
  localparam int NIB_W = 4;
  localparam int DIGIT_COUNT = 10;
  localparam int BCD_W = NIB_W * DIGIT_COUNT;
  localparam int STEP_W = $clog2(NUM_W);
  localparam int LEFT_W = $clog2(DIGIT_COUNT + 1);

  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] ZERO_CHAR = 8'd48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } s2d_state_t;

endpackage : s2d_pkg

`default_nettype wire

@@ hw/rtl/s2d_dabble.sv @@
// Bit-serial binary to BCD converter (shift and add 3), one magnitude bit per cycle.
// Depends on s2d_pkg for widths.
`default_nettype none

module s2d_dabble
  import s2d_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire logic [NUM_W-1:0]   load_value,
  output logic                    done,
  output logic [BCD_W-1:0]        bcd
);

  logic [NUM_W-1:0]  mag_r, mag_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [STEP_W-1:0] count_r, count_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [BCD_W-1:0]  adj;

  // Every digit of five or more gets three added before the shift.
  always_comb begin
    adj = bcd_r;
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      if (bcd_r[d*NIB_W +: NIB_W] >= NIB_W'(5)) begin
        adj[d*NIB_W +: NIB_W] = bcd_r[d*NIB_W +: NIB_W] + NIB_W'(3);
      end
    end
  end

  always_comb begin
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    count_nxt = count_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    if (load) begin
      mag_nxt   = load_value;
      bcd_nxt   = '0;
      count_nxt = '0;
      run_nxt   = 1'b1;
    end else if (run_r) begin
      bcd_nxt   = {adj[BCD_W-2:0], mag_r[NUM_W-1]};
      mag_nxt   = {mag_r[NUM_W-2:0], 1'b0};
      count_nxt = count_r + STEP_W'(1);
      if (count_r == STEP_W'(NUM_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      run_r   <= run_nxt;
      done_r  <= done_nxt;
      count_r <= count_nxt;
    end
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

  a_done_not_running: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r)
    else $error("conversion done while still shifting");

  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && !load && count_r == STEP_W'(NUM_W - 1)) |=> done_r)
    else $error("final shift did not raise done");

  a_load_runs: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (run_r && count_r == '0 && !done_r))
    else $error("load did not start a conversion");

endmodule : s2d_dabble

`default_nettype wire

@@ hw/rtl/signed_int_to_decimal_ascii.sv @@
// Characters leave one per cycle once the first appears after the start transfer.
// A new number is not accepted while busy, which lasts until the last character leaves.
// The bit-serial BCD converter runs 32 steps, then leading zeros are skipped and digits emitted.
// Results leave as one-cycle strobes; the receiver cannot stall them.
// Synchronous active-low reset returns to idle with no result pending.
// Top level; depends on s2d_pkg and s2d_dabble.
`default_nettype none

module signed_int_to_decimal_ascii
  import s2d_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [NUM_W-1:0]   in_number,
  output logic                    out_valid,
  output logic [7:0]              out_character,
  output logic                    out_last_char
);

  s2d_state_t        state_r, state_nxt;
  logic              sign_r, sign_nxt;
  logic [BCD_W-1:0]  shift_r, shift_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  logic [NUM_W-1:0]  magnitude;
  logic              conv_done;
  logic [BCD_W-1:0]  conv_bcd;
  logic [NIB_W-1:0]  top_digit;
  logic              lead_zero;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Two's complement magnitude; the most negative value yields 2^31 unsigned.
  assign magnitude = in_number[NUM_W-1] ? (~in_number + NUM_W'(1)) : in_number;

  s2d_dabble u_dabble (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .load_value (magnitude),
    .done       (conv_done),
    .bcd        (conv_bcd)
  );

  assign top_digit = shift_r[BCD_W-1 -: NIB_W];
  assign lead_zero = (top_digit == '0) && (left_r != LEFT_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (conv_done) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!lead_zero) begin
          state_nxt = sign_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (left_r == LEFT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sign_nxt      = sign_r;
    shift_nxt     = shift_r;
    left_nxt      = left_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sign_nxt = in_number[NUM_W-1];
        end
      end
      ST_CONVERT: begin
        if (conv_done) begin
          shift_nxt = conv_bcd;
          left_nxt  = LEFT_W'(DIGIT_COUNT);
        end
      end
      ST_SKIP: begin
        // Drop one leading zero per cycle, always keeping the units digit.
        if (lead_zero) begin
          shift_nxt = {shift_r[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
          left_nxt  = left_r - LEFT_W'(1);
        end
      end
      ST_SIGN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = MINUS_CHAR;
        out_last_nxt  = 1'b0;
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = ZERO_CHAR + 8'(top_digit);
        out_last_nxt  = (left_r == LEFT_W'(1));
        shift_nxt     = {shift_r[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
        left_nxt      = left_r - LEFT_W'(1);
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sign_r     <= sign_nxt;
    shift_r    <= shift_nxt;
    left_r     <= left_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last_char = out_last_r;

  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_char) |=> out_valid)
    else $error("character run broken before its last transfer");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy && !out_valid))
    else $error("output strobe right after accepting a number");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_character == MINUS_CHAR) |-> !out_last_char)
    else $error("minus sign flagged as last character");

  a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_char) |-> !busy)
    else $error("block still busy on the last character");

endmodule : signed_int_to_decimal_ascii

`default_nettype wire
